>>> src/home_computer_bank_decoder_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bank decoder.
// Each macro expands to one labeled concurrent assertion that is clocked on
// the rising edge and disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef HOME_COMPUTER_BANK_DECODER_ASSERT_SVH
`define HOME_COMPUTER_BANK_DECODER_ASSERT_SVH

// The condition must hold at every clock edge outside reset.
`define HCBD_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The antecedent implies the consequent in the same cycle.
`define HCBD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The antecedent implies the consequent in the following cycle.
`define HCBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/hcbd_pkg.sv
// ----------------------------------------------------------------------------
// hcbd_pkg
// Types and constants shared by the bank decoder, its checker and its testbench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hcbd_pkg;

  // Bus operation codes.
  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_LOAD  = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  // Device select codes.
  typedef enum logic [1:0] {
    DEV_NONE  = 2'd0,
    DEV_VIDEO = 2'd1,
    DEV_IO    = 2'd2
  } dev_e;

  // What the D000-DFFF window maps for a given banking mode.
  typedef enum logic [1:0] {
    BANK_RAM,
    BANK_IO,
    BANK_CHAR
  } bank_e;

  // Where the read data of an access comes from.
  typedef enum logic [1:0] {
    SRC_CONST,
    SRC_RAM,
    SRC_ROM
  } src_e;

  localparam int unsigned RamAw = 16;
  localparam int unsigned RomAw = 14;

  localparam logic [15:0] ModeAddr   = 16'h0001;
  localparam logic [7:0]  ModeReset  = 8'h01;
  localparam logic [7:0]  RamReset   = 8'h01;
  localparam logic [7:0]  FillByte   = 8'hFF;
  localparam logic [5:0]  VidFirstFf = 6'h2F;

  localparam logic [1:0] BitsRom   = 2'b11;
  localparam logic [7:0] ModeChar0 = 8'h00;
  localparam logic [7:0] ModeChar4 = 8'h04;

  // One bus operation.
  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [15:0] program_counter;
    logic [13:0] rom_offset;
  } in_t;

  // One result.
  typedef struct packed {
    logic [7:0]  read_data;
    logic [1:0]  device_select;
    logic [8:0]  device_offset;
    logic        device_is_write;
    logic [7:0]  device_data;
    logic [15:0] device_pc;
  } out_t;

endpackage

>>> src/home_computer_bank_decoder.sv
// ----------------------------------------------------------------------------
// home_computer_bank_decoder
// Banked memory decoder with built-in 64 KiB RAM and 16 KiB ROM.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass that sets every RAM byte to 1;
// in_ready_o stays low while it runs. After that one bus operation can be
// accepted every cycle, unless the output register holds a result that the
// receiver has not taken. The transfer edge itself performs the synchronous
// read of the single-port RAM or ROM, and a later edge, once the output
// register is free, selects the read data into the output register. Writes
// and ROM loads go into memory in the cycle they are accepted, so a following
// read already sees them. The ROM is not cleared; reading a byte that was never
// loaded returns an undefined value.
`timescale 1ns / 1ps

`include "home_computer_bank_decoder_assert.svh"

module home_computer_bank_decoder (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  hcbd_pkg::in_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output hcbd_pkg::out_t out_data_o
);
  import hcbd_pkg::*;

  // Memories.
  logic [7:0] ram_mem [2**RamAw];
  logic [7:0] rom_mem [2**RomAw];

  logic [7:0] ram_rdata_q;
  logic [7:0] rom_rdata_q;

  // Control state.
  logic             clearing_q, clearing_d;
  logic [RamAw-1:0] clr_cnt_q, clr_cnt_d;
  logic [7:0]       mode_q, mode_d;
  logic             s1_valid_q, s1_valid_d;
  src_e             s1_src_q, s1_src_d;
  out_t             s1_res_q, s1_res_d;
  logic             out_valid_q, out_valid_d;
  out_t             out_q, out_d;

  // Memory port controls.
  logic             ram_we, ram_re, acc_ram_we;
  logic [RamAw-1:0] ram_waddr;
  logic [7:0]       ram_wdata;
  logic             rom_we, rom_re;
  logic [RomAw-1:0] rom_raddr;

  logic  in_accept;
  logic  out_free;
  bank_e bank;
  op_e   op;
  logic [15:0] addr;
  logic [5:0]  vid_off;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = !clearing_q && (!s1_valid_q || out_free);
  assign in_accept  = in_valid_i && in_ready_o;

  assign op      = op_e'(in_data_i.operation);
  assign addr    = in_data_i.address;
  assign vid_off = addr[5:0];

  // Map the D000-DFFF window from the current banking mode.
  always_comb begin
    if (mode_q == ModeChar0 || mode_q == ModeChar4) begin
      bank = BANK_RAM;
    end else if (mode_q[2]) begin
      bank = BANK_IO;
    end else begin
      bank = BANK_CHAR;
    end
  end

  // ROM index: A000-BFFF maps to the lower half, E000-FFFF to the upper half.
  assign rom_raddr = {addr[14], addr[12:0]};

  // Decode the accepted operation into memory accesses and a partial result.
  always_comb begin
    acc_ram_we = 1'b0;
    ram_re     = 1'b0;
    rom_we     = 1'b0;
    rom_re     = 1'b0;
    s1_src_d   = SRC_CONST;
    s1_res_d   = '0;
    unique case (op)
      OP_LOAD: begin
        rom_we = 1'b1;
      end
      OP_READ: begin
        if (addr[15:13] == 3'b101) begin
          if ((mode_q[1:0] & BitsRom) == BitsRom) rom_re = 1'b1;
          else ram_re = 1'b1;
        end else if (addr[15:13] == 3'b111) begin
          if (mode_q[1]) rom_re = 1'b1;
          else ram_re = 1'b1;
        end else if (addr[15:12] == 4'hD) begin
          unique case (bank)
            BANK_RAM: ram_re = 1'b1;
            BANK_CHAR: s1_res_d.read_data = FillByte;
            default: begin
              if (addr[11:10] == 2'b00) begin
                if (vid_off >= VidFirstFf) begin
                  s1_res_d.read_data = FillByte;
                end else begin
                  s1_res_d.device_select = DEV_VIDEO;
                  s1_res_d.device_offset = {3'b000, vid_off};
                end
              end else if (addr[11:9] == 3'b110) begin
                s1_res_d.device_select = DEV_IO;
                s1_res_d.device_offset = addr[8:0];
              end else begin
                ram_re = 1'b1;
              end
            end
          endcase
        end else begin
          ram_re = 1'b1;
        end
      end
      OP_WRITE: begin
        if (addr[15:12] == 4'hD && bank == BANK_IO) begin
          if (addr[11:10] == 2'b00) begin
            if (vid_off < VidFirstFf) begin
              s1_res_d.device_select   = DEV_VIDEO;
              s1_res_d.device_offset   = {3'b000, vid_off};
              s1_res_d.device_is_write = 1'b1;
              s1_res_d.device_data     = in_data_i.write_data;
            end
          end else if (addr[11:9] == 3'b110) begin
            s1_res_d.device_select   = DEV_IO;
            s1_res_d.device_offset   = addr[8:0];
            s1_res_d.device_is_write = 1'b1;
            s1_res_d.device_data     = in_data_i.write_data;
            s1_res_d.device_pc       = in_data_i.program_counter;
          end else if (addr[11:10] == 2'b10) begin
            acc_ram_we = 1'b1;
          end
        end else begin
          acc_ram_we = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (ram_re) s1_src_d = SRC_RAM;
    if (rom_re) s1_src_d = SRC_ROM;
    // Nothing happens to memory unless the transfer completes.
    acc_ram_we = acc_ram_we && in_accept;
    ram_re     = ram_re && in_accept;
    rom_we     = rom_we && in_accept;
    rom_re     = rom_re && in_accept;
  end

  // RAM write port: the clearing pass owns it until it is done.
  always_comb begin
    if (clearing_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
      ram_wdata = RamReset;
    end else begin
      ram_we    = acc_ram_we;
      ram_waddr = addr;
      ram_wdata = in_data_i.write_data;
    end
  end

  // RAM array with registered read data.
  always_ff @(posedge clk_i) begin
    if (ram_we) ram_mem[ram_waddr] <= ram_wdata;
    if (ram_re) ram_rdata_q <= ram_mem[addr];
  end

  // ROM array with registered read data.
  always_ff @(posedge clk_i) begin
    if (rom_we) rom_mem[in_data_i.rom_offset] <= in_data_i.write_data;
    if (rom_re) rom_rdata_q <= rom_mem[rom_raddr];
  end

  // Clearing pass and banking mode copy.
  always_comb begin
    clearing_d = clearing_q;
    clr_cnt_d  = clr_cnt_q;
    if (clearing_q) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
      if (&clr_cnt_q) clearing_d = 1'b0;
    end
    mode_d = mode_q;
    if (acc_ram_we && addr == ModeAddr) mode_d = in_data_i.write_data;
  end

  // Pipeline: decode stage, then output register.
  always_comb begin
    s1_valid_d  = s1_valid_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_free) begin
      out_valid_d = s1_valid_q;
      out_d       = s1_res_q;
      case (s1_src_q)
        SRC_RAM: out_d.read_data = ram_rdata_q;
        SRC_ROM: out_d.read_data = rom_rdata_q;
        default: out_d.read_data = s1_res_q.read_data;
      endcase
      s1_valid_d = 1'b0;
    end
    if (in_accept) s1_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q  <= 1'b1;
      clr_cnt_q   <= '0;
      mode_q      <= ModeReset;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      clearing_q  <= clearing_d;
      clr_cnt_q   <= clr_cnt_d;
      mode_q      <= mode_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_src_q <= s1_src_d;
      s1_res_q <= s1_res_d;
    end
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Assertions.
  `HCBD_ASSERT_SAME(a_no_accept_clearing, clk_i, rst_ni, clearing_q, !in_ready_o, "transfer accepted during RAM clearing")
  `HCBD_ASSERT_ALWAYS(a_single_port, clk_i, rst_ni, !(ram_we && ram_re), "RAM read and written in one cycle")
  `HCBD_ASSERT_NEXT(a_mode_tracks, clk_i, rst_ni, acc_ram_we && addr == ModeAddr, mode_q == $past(in_data_i.write_data), "mode copy missed a write")
  `HCBD_ASSERT_NEXT(a_stage_advance, clk_i, rst_ni, s1_valid_q && out_free, out_valid_q, "decoded item did not reach the output")
  `HCBD_ASSERT_SAME(a_rom_needs_hiram, clk_i, rst_ni, rom_re, mode_q[1] && !clearing_q, "ROM read without HIRAM")

endmodule

>>> test/home_computer_bank_decoder_checker.sv
// ----------------------------------------------------------------------------
// home_computer_bank_decoder_checker
// Watches both channels of the bank decoder, keeps its own image of the RAM,
// the ROM and the banking mode, predicts each result from the accepted bus
// operations and compares every result transfer field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module home_computer_bank_decoder_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_ready_i,
  input  hcbd_pkg::in_t  in_data_i,
  input  logic           out_valid_i,
  input  logic           out_ready_i,
  input  hcbd_pkg::out_t out_data_i,
  output int             fail_count_o,
  output int             pending_o
);
  import hcbd_pkg::*;

  // Shadow of the memories and of the banking mode byte.
  logic [7:0] ram_image [65536];
  logic [7:0] rom_image [16384];
  logic [7:0] mode_byte;

  // Results predicted but not yet seen on the output channel.
  out_t expected_results [$];
  int   mismatches;

  // Works out the result of one bus operation and applies its side effects.
  function automatic out_t decode_bus_op(in_t op);
    out_t       res;
    logic [7:0] pg;
    logic [5:0] vid;
    bank_e      win;
    res = '0;
    pg  = op.address[15:8];
    vid = op.address[5:0];
    if (mode_byte == ModeChar0 || mode_byte == ModeChar4) begin
      win = BANK_RAM;
    end else if (mode_byte[2]) begin
      win = BANK_IO;
    end else begin
      win = BANK_CHAR;
    end
    case (op.operation)
      OP_LOAD: begin
        rom_image[op.rom_offset] = op.write_data;
      end
      OP_READ: begin
        if (op.address[15:13] == 3'b101) begin
          // Basic ROM needs both LORAM and HIRAM.
          res.read_data = (mode_byte[1:0] == BitsRom) ? rom_image[{1'b0, op.address[12:0]}]
                                                       : ram_image[op.address];
        end else if (op.address[15:13] == 3'b111) begin
          // Kernal ROM needs HIRAM alone.
          res.read_data = mode_byte[1] ? rom_image[{1'b1, op.address[12:0]}]
                                       : ram_image[op.address];
        end else if (pg[7:4] == 4'hD) begin
          if (win == BANK_RAM) begin
            res.read_data = ram_image[op.address];
          end else if (win == BANK_CHAR) begin
            res.read_data = FillByte;
          end else if (pg <= 8'hD3) begin
            // Video registers mirror every 64 bytes; the top of each copy is unused.
            if (vid >= VidFirstFf) begin
              res.read_data = FillByte;
            end else begin
              res.device_select = DEV_VIDEO;
              res.device_offset = {3'b000, vid};
            end
          end else if (pg == 8'hDC || pg == 8'hDD) begin
            res.device_select = DEV_IO;
            res.device_offset = op.address[8:0];
          end else begin
            res.read_data = ram_image[op.address];
          end
        end else begin
          res.read_data = ram_image[op.address];
        end
      end
      OP_WRITE: begin
        if (pg[7:4] == 4'hD && win == BANK_IO) begin
          if (pg <= 8'hD3) begin
            if (vid < VidFirstFf) begin
              res.device_select   = DEV_VIDEO;
              res.device_offset   = {3'b000, vid};
              res.device_is_write = 1'b1;
              res.device_data     = op.write_data;
            end
          end else if (pg == 8'hDC || pg == 8'hDD) begin
            res.device_select   = DEV_IO;
            res.device_offset   = op.address[8:0];
            res.device_is_write = 1'b1;
            res.device_data     = op.write_data;
            res.device_pc       = op.program_counter;
          end else if (pg >= 8'hD8 && pg <= 8'hDB) begin
            // Color RAM pages stay writable in I/O mode.
            ram_image[op.address] = op.write_data;
          end
        end else begin
          // Writes under ROM and everywhere else land in RAM.
          ram_image[op.address] = op.write_data;
          if (op.address == ModeAddr) begin
            mode_byte = op.write_data;
          end
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // Reports one field that differs from its prediction.
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Result transfers are matched first, so a result never pairs with an
  // access accepted at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      foreach (ram_image[a]) ram_image[a] = RamReset;
      mode_byte = ModeReset;
      expected_results.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no access pending");
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("read_data", want.read_data, out_data_i.read_data);
          check_field("device_select", want.device_select, out_data_i.device_select);
          check_field("device_offset", want.device_offset, out_data_i.device_offset);
          check_field("device_is_write", want.device_is_write, out_data_i.device_is_write);
          check_field("device_data", want.device_data, out_data_i.device_data);
          check_field("device_pc", want.device_pc, out_data_i.device_pc);
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_results.push_back(decode_bus_op(in_data_i));
      end
      fail_count_o <= mismatches;
      pending_o    <= expected_results.size();
    end
  end

endmodule

>>> test/tb_home_computer_bank_decoder.sv
// ----------------------------------------------------------------------------
// tb_home_computer_bank_decoder
// Drives bus reads, writes and ROM loads into the bank decoder under changing
// banking modes and random flow control, and reports the checker's verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_home_computer_bank_decoder;
  import hcbd_pkg::*;

  localparam int ItemsPerPhase = 400;
  localparam logic [7:0] ModePicks [8] = '{8'h00, 8'h04, 8'h07, 8'h06,
                                           8'h03, 8'h05, 8'h01, 8'hFF};

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_ready_o;
  in_t  in_data_i   = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;

  int fail_count;
  int pending_count;
  int send_idle_pct = 6;
  int recv_stall_pct = 72;

  // Stimulus-side view of the banking mode and of which ROM bytes hold data.
  logic [7:0]  bank_mode = ModeReset;
  bit          rom_loaded [16384];
  logic [15:0] hot_addrs [$];

  always #2ns clk_i = ~clk_i;

  home_computer_bank_decoder i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  home_computer_bank_decoder_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_i   (out_data_o),
    .fail_count_o (fail_count),
    .pending_o    (pending_count)
  );

  // The receiver stalls at random with the current phase's rate.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Sends one bus operation. A read that would hit a ROM byte never loaded
  // is preceded by a load of that byte.
  task automatic issue(input op_e opc, input logic [15:0] addr, input logic [7:0] data,
                       input logic [15:0] pc, input logic [13:0] roff);
    in_t seq [$];
    in_t it;
    int  rom_idx;
    rom_idx = -1;
    if (opc == OP_READ) begin
      if (addr[15:13] == 3'b101 && bank_mode[1:0] == BitsRom) begin
        rom_idx = {1'b0, addr[12:0]};
      end else if (addr[15:13] == 3'b111 && bank_mode[1]) begin
        rom_idx = {1'b1, addr[12:0]};
      end
    end
    if (rom_idx >= 0 && !rom_loaded[rom_idx]) begin
      it.operation       = OP_LOAD;
      it.address         = 16'($urandom);
      it.write_data      = 8'($urandom);
      it.program_counter = 16'($urandom);
      it.rom_offset      = 14'(rom_idx);
      seq.push_back(it);
    end
    it.operation       = opc;
    it.address         = addr;
    it.write_data      = data;
    it.program_counter = pc;
    it.rom_offset      = roff;
    seq.push_back(it);
    foreach (seq[i]) begin
      if (seq[i].operation == OP_LOAD) begin
        rom_loaded[seq[i].rom_offset] = 1'b1;
      end
      if (seq[i].operation == OP_WRITE && seq[i].address == ModeAddr) begin
        bank_mode = seq[i].write_data;
      end
      if ($urandom_range(99) < send_idle_pct) begin
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
      end
      in_valid_i <= 1'b1;
      in_data_i  <= seq[i];
      do @(posedge clk_i); while (!in_ready_o);
    end
  endtask

  // Holds the sender off until every predicted result has been transferred.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
  endtask

  // Stimulus: directed accesses, then three phases of random traffic.
  initial begin
    int          sent;
    int          roll;
    int          zone;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [15:0] pc;
    logic [13:0] roff;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset mode: LORAM only, so D000 shows character ROM and the ROMs are hidden.
    issue(OP_READ,  ModeAddr, 8'h00, 16'h0000, 14'h0000);
    issue(OP_READ,  16'hD000, 8'h00, 16'h0000, 14'h0000);
    issue(OP_WRITE, 16'hD123, 8'h5A, 16'h0000, 14'h0000);
    issue(OP_LOAD,  16'h0000, 8'h00, 16'h0000, 14'h0000);
    issue(OP_LOAD,  16'hFFFF, 8'hFF, 16'hFFFF, 14'h1FFF);
    issue(OP_LOAD,  16'h0000, 8'hA5, 16'h0000, 14'h2000);
    issue(OP_LOAD,  16'hFFFF, 8'h3C, 16'hFFFF, 14'h3FFF);
    // Full I/O mode with both ROMs mapped.
    issue(OP_WRITE, ModeAddr, 8'h07, 16'h0000, 14'h0000);
    issue(OP_READ,  16'hA000, 8'h00, 16'h0000, 14'h0000);
    issue(OP_READ,  16'hBFFF, 8'h00, 16'h0000, 14'h0000);
    issue(OP_READ,  16'hE000, 8'h00, 16'h0000, 14'h0000);
    issue(OP_READ,  16'hFFFF, 8'h00, 16'h0000, 14'h0000);
    // Video window: first register, last live register, first unused one, dropped write.
    issue(OP_READ,  16'hD000, 8'h00, 16'h0000, 14'h0000);
    issue(OP_WRITE, 16'hD3EE, 8'hFF, 16'hFFFF, 14'h3FFF);
    issue(OP_READ,  16'hD02F, 8'h00, 16'h0000, 14'h0000);
    issue(OP_WRITE, 16'hD07F, 8'h12, 16'h1234, 14'h0000);
    // Io controller at both ends of its window.
    issue(OP_WRITE, 16'hDC00, 8'h81, 16'hFFFF, 14'h0000);
    issue(OP_READ,  16'hDDFF, 8'h00, 16'h0000, 14'h0000);
    // Color RAM stays writable; the sound pages drop writes.
    issue(OP_WRITE, 16'hD800, 8'h33, 16'h0000, 14'h0000);
    issue(OP_READ,  16'hD800, 8'h00, 16'h0000, 14'h0000);
    issue(OP_WRITE, 16'hD400, 8'h77, 16'h0000, 14'h0000);
    issue(OP_READ,  16'hD400, 8'h00, 16'h0000, 14'h0000);
    // CHAREN alone maps RAM at D000 again.
    issue(OP_WRITE, ModeAddr, 8'h04, 16'h0000, 14'h0000);
    issue(OP_READ,  16'hD123, 8'h00, 16'h0000, 14'h0000);
    issue(OP_NOP,   16'hFFFF, 8'hFF, 16'hFFFF, 14'h3FFF);
    drain_results();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct  = (phase == 0) ? 6 : (phase == 1) ? 72 : 0;
      recv_stall_pct = (phase == 0) ? 72 : (phase == 1) ? 6 : 0;
      sent = 0;
      while (sent < ItemsPerPhase) begin
        roll = $urandom_range(99);
        addr = 16'($urandom);
        data = 8'($urandom);
        pc   = 16'($urandom);
        roff = 14'($urandom);
        if (roll < 8) begin
          // Banking mode change, mostly to the interesting values.
          if ($urandom_range(3) != 0) data = ModePicks[$urandom_range(7)];
          issue(OP_WRITE, ModeAddr, data, pc, roff);
          sent++;
        end else if (roll < 14) begin
          issue(OP_LOAD, addr, data, pc, roff);
          sent++;
        end else if (roll < 16) begin
          issue(OP_NOP, addr, data, pc, roff);
        end else begin
          zone = $urandom_range(7);
          case (zone)
            1: addr = {6'b110100, addr[9:0]};
            2: addr = {4'hD, addr[11:0]};
            3: addr = {7'b1101110, addr[8:0]};
            4: begin
              addr[15:13] = 3'b101;
              if ($urandom_range(1) != 0) addr[12:4] = '0;
            end
            5: begin
              addr[15:13] = 3'b111;
              if ($urandom_range(1) != 0) addr[12:4] = '0;
            end
            6: if (hot_addrs.size() != 0) addr = hot_addrs[$urandom_range(hot_addrs.size() - 1)];
            7: addr[15:8] = 8'h00;
            default: begin
            end
          endcase
          if ($urandom_range(99) < 55) begin
            issue(OP_READ, addr, data, pc, roff);
          end else begin
            issue(OP_WRITE, addr, data, pc, roff);
            hot_addrs.push_back(addr);
            if (hot_addrs.size() > 32) void'(hot_addrs.pop_front());
          end
          sent++;
        end
      end
      drain_results();
    end

    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_home_computer_bank_decoder passed");
    end else begin
      $display("tb_home_computer_bank_decoder failed");
    end
    $finish;
  end

  // Watchdog: covers the RAM clearing pass and the slowest flow-control phases.
  initial begin
    #2_000_000ns;
    $display("tb_home_computer_bank_decoder failed");
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/hcbd_pkg.sv
src/home_computer_bank_decoder.sv
test/home_computer_bank_decoder_checker.sv
test/tb_home_computer_bank_decoder.sv
